// ----- rtl/core/reaction_diffusion_stencil_step_core_assert.svh -----
// Assertion macros shared by the core.
`ifndef REACTION_DIFFUSION_STENCIL_STEP_CORE_ASSERT_SVH
`define REACTION_DIFFUSION_STENCIL_STEP_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define RDSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define RDSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define RDSS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rdss_pkg.sv -----
`timescale 1ns / 1ps

package rdss_pkg;

   localparam int MAX_COLS    = 512;
   localparam int MAX_ROWS    = 4096;
   localparam int VALUE_W     = 16;
   localparam int FRAC_BITS   = 12;

   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int COLS_EFF_W  = COL_W + 1;
   localparam int ROW_W       = $clog2(MAX_ROWS) + 1;
   localparam int COLS_CFG_W  = 10;
   localparam int ROWS_CFG_W  = 13;
   localparam int PARAM_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int DIFF_W      = VALUE_W + 2;
   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = PARAM_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int CHUNK_W     = MUL_A_W - 1;
   localparam int X_W         = 46;
   localparam int ACC_W       = 62;
   localparam int ONE_SHIFT   = 2 * FRAC_BITS;
   localparam int GAIN_SHIFT  = 4;
   localparam int RATE_SHIFT  = 12;
   localparam int INC_SHIFT   = 28;
   localparam int SUM_W       = ACC_W - INC_SHIFT;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIFF_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_X_SQ   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_Y_SQ   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS       = 3'd5;

   localparam logic [PARAM_W-1:0]    TIME_STEP_RST  = 16'd655;
   localparam logic [PARAM_W-1:0]    DIFF_GAIN_RST  = 16'd4096;
   localparam logic [PARAM_W-1:0]    INV_X_SQ_RST   = 16'd259;
   localparam logic [PARAM_W-1:0]    INV_Y_SQ_RST   = 16'd262;
   localparam logic [COLS_CFG_W-1:0] COLS_RST       = 10'd512;
   localparam logic [ROWS_CFG_W-1:0] ROWS_RST       = 13'd512;

   localparam logic CMD_CELL  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef enum logic [2:0] {
      A_SX,
      A_SY,
      A_CENTER,
      A_PROD,
      A_X_LO,
      A_X_HI
   } mul_a_sel_type;

   typedef enum logic [2:0] {
      B_INV_X,
      B_INV_Y,
      B_GAIN,
      B_CENTER,
      B_STEP
   } mul_b_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB,
      ACC_CUBE_BASE
   } acc_op_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_GAIN,
      SH_CHUNK,
      SH_CHUNK_GAIN
   } shift_sel_type;

   typedef enum logic [1:0] {
      X_HOLD,
      X_LOAD_ACC,
      X_LOAD_RATE
   } x_op_type;

   typedef struct packed {
      logic             clear_wr;
      logic [COL_W-1:0] clear_addr;
      logic             item_load;
      logic             item_apply;
      mul_a_sel_type    a_sel;
      mul_b_sel_type    b_sel;
      acc_op_type       acc_op;
      shift_sel_type    shift_sel;
      x_op_type         x_op;
      logic             out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;
   } status_type;

endpackage

// ----- rtl/core/rdss_ctrl.sv -----
`timescale 1ns / 1ps

module rdss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  rdss_pkg::status_type status,
   output rdss_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LAP_X,
      ST_LAP_Y,
      ST_SQUARE,
      ST_CUBE,
      ST_GAIN_LO,
      ST_GAIN_HI,
      ST_GAIN_ACC,
      ST_RATE,
      ST_STEP_LO,
      ST_STEP_HI,
      ST_STEP_ACC,
      ST_FINISH
   } state_type;

   state_type                      state_ff;
   state_type                      state_in;
   logic [rdss_pkg::COL_W-1:0]     clear_cnt_ff;
   logic [rdss_pkg::COL_W-1:0]     clear_cnt_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clear_cnt_in   = clear_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      cmd.clear_wr   = 1'b0;
      cmd.clear_addr = clear_cnt_ff;
      cmd.item_load  = 1'b0;
      cmd.item_apply = 1'b0;
      cmd.a_sel      = rdss_pkg::A_SX;
      cmd.b_sel      = rdss_pkg::B_INV_X;
      cmd.acc_op     = rdss_pkg::ACC_HOLD;
      cmd.shift_sel  = rdss_pkg::SH_NONE;
      cmd.x_op       = rdss_pkg::X_HOLD;
      cmd.out_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == rdss_pkg::COL_W'(rdss_pkg::MAX_COLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.item_load = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.item_apply = 1'b1;
            state_in       = status.emit ? ST_LAP_X : ST_IDLE;
         end
         ST_LAP_X: begin
            cmd.a_sel = rdss_pkg::A_SX;
            cmd.b_sel = rdss_pkg::B_INV_X;
            state_in  = ST_LAP_Y;
         end
         ST_LAP_Y: begin
            cmd.a_sel  = rdss_pkg::A_SY;
            cmd.b_sel  = rdss_pkg::B_INV_Y;
            cmd.acc_op = rdss_pkg::ACC_LOAD;
            state_in   = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.a_sel  = rdss_pkg::A_CENTER;
            cmd.b_sel  = rdss_pkg::B_CENTER;
            cmd.acc_op = rdss_pkg::ACC_ADD;
            state_in   = ST_CUBE;
         end
         ST_CUBE: begin
            cmd.a_sel  = rdss_pkg::A_PROD;
            cmd.b_sel  = rdss_pkg::B_CENTER;
            cmd.x_op   = rdss_pkg::X_LOAD_ACC;
            cmd.acc_op = rdss_pkg::ACC_CUBE_BASE;
            state_in   = ST_GAIN_LO;
         end
         ST_GAIN_LO: begin
            cmd.a_sel  = rdss_pkg::A_X_LO;
            cmd.b_sel  = rdss_pkg::B_GAIN;
            cmd.acc_op = rdss_pkg::ACC_SUB;
            state_in   = ST_GAIN_HI;
         end
         ST_GAIN_HI: begin
            cmd.a_sel     = rdss_pkg::A_X_HI;
            cmd.b_sel     = rdss_pkg::B_GAIN;
            cmd.acc_op    = rdss_pkg::ACC_ADD;
            cmd.shift_sel = rdss_pkg::SH_GAIN;
            state_in      = ST_GAIN_ACC;
         end
         ST_GAIN_ACC: begin
            cmd.acc_op    = rdss_pkg::ACC_ADD;
            cmd.shift_sel = rdss_pkg::SH_CHUNK_GAIN;
            state_in      = ST_RATE;
         end
         ST_RATE: begin
            cmd.x_op = rdss_pkg::X_LOAD_RATE;
            state_in = ST_STEP_LO;
         end
         ST_STEP_LO: begin
            cmd.a_sel = rdss_pkg::A_X_LO;
            cmd.b_sel = rdss_pkg::B_STEP;
            state_in  = ST_STEP_HI;
         end
         ST_STEP_HI: begin
            cmd.a_sel  = rdss_pkg::A_X_HI;
            cmd.b_sel  = rdss_pkg::B_STEP;
            cmd.acc_op = rdss_pkg::ACC_LOAD;
            state_in   = ST_STEP_ACC;
         end
         ST_STEP_ACC: begin
            cmd.acc_op    = rdss_pkg::ACC_ADD;
            cmd.shift_sel = rdss_pkg::SH_CHUNK;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/core/rdss_datapath.sv -----
`timescale 1ns / 1ps

module rdss_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [rdss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rdss_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [rdss_pkg::VALUE_W-1:0]        req_tdata,
   input  logic                                req_tuser,
   input  rdss_pkg::cmd_type                   cmd,
   output rdss_pkg::status_type                status,
   output logic [rdss_pkg::VALUE_W-1:0]        rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int VW = rdss_pkg::VALUE_W;

   localparam logic signed [rdss_pkg::SUM_W-1:0] SAT_HI =
      rdss_pkg::SUM_W'((2 ** (VW - 1)) - 1);
   localparam logic signed [rdss_pkg::SUM_W-1:0] SAT_LO =
      rdss_pkg::SUM_W'(-(2 ** (VW - 1)));

   logic [rdss_pkg::PARAM_W-1:0]         time_step_ff;
   logic [rdss_pkg::PARAM_W-1:0]         diff_gain_ff;
   logic [rdss_pkg::PARAM_W-1:0]         inv_x_sq_ff;
   logic [rdss_pkg::PARAM_W-1:0]         inv_y_sq_ff;
   logic [rdss_pkg::COLS_CFG_W-1:0]      cols_cfg_ff;
   logic [rdss_pkg::ROWS_CFG_W-1:0]      rows_cfg_ff;

   logic [rdss_pkg::COLS_EFF_W-1:0]      cols_eff;
   logic [rdss_pkg::ROW_W-1:0]           rows_eff;

   logic signed [VW-1:0]                 row_above_mem [rdss_pkg::MAX_COLS];
   logic signed [VW-1:0]                 row_two_back_mem [rdss_pkg::MAX_COLS];
   logic                                 store_we;
   logic [rdss_pkg::COL_W-1:0]           store_addr;
   logic signed [VW-1:0]                 above_wdata;
   logic signed [VW-1:0]                 two_back_wdata;

   logic                                 item_flush_ff;
   logic signed [VW-1:0]                 cell_ff;
   logic signed [VW-1:0]                 center_rd_ff;
   logic signed [VW-1:0]                 right_rd_ff;
   logic signed [VW-1:0]                 up_rd_ff;

   logic [rdss_pkg::COL_W-1:0]           col_ff;
   logic [rdss_pkg::COL_W-1:0]           col_in;
   logic [rdss_pkg::ROW_W-1:0]           row_ff;
   logic [rdss_pkg::ROW_W-1:0]           row_in;
   logic [rdss_pkg::ROW_W-1:0]           row_plus;
   logic                                 flushing_ff;
   logic                                 flushing_in;
   logic signed [VW-1:0]                 left_ff;

   logic [rdss_pkg::COLS_EFF_W-1:0]      col_plus;
   logic                                 item_valid;
   logic                                 row_end;
   logic signed [VW-1:0]                 down;
   logic signed [VW-1:0]                 up;
   logic signed [VW-1:0]                 left;
   logic signed [VW-1:0]                 right;
   logic signed [rdss_pkg::DIFF_W-1:0]   sx_in;
   logic signed [rdss_pkg::DIFF_W-1:0]   sy_in;

   logic signed [VW-1:0]                 center_ff;
   logic signed [rdss_pkg::DIFF_W-1:0]   sx_ff;
   logic signed [rdss_pkg::DIFF_W-1:0]   sy_ff;
   logic                                 last_ff;

   logic signed [rdss_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [rdss_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [rdss_pkg::PROD_W-1:0]   prod_ff;
   logic signed [rdss_pkg::ACC_W-1:0]    prod_ext;
   logic signed [rdss_pkg::ACC_W-1:0]    prod_sh;
   logic signed [rdss_pkg::ACC_W-1:0]    acc_ff;
   logic signed [rdss_pkg::ACC_W-1:0]    acc_in;
   logic signed [rdss_pkg::X_W-1:0]      x_ff;
   logic signed [rdss_pkg::X_W-1:0]      x_in;
   logic signed [rdss_pkg::ACC_W-1:0]    rate_full;
   logic signed [rdss_pkg::ACC_W-1:0]    inc_full;
   logic signed [rdss_pkg::SUM_W-1:0]    sum;
   logic signed [VW-1:0]                 sat_value;

   logic [VW-1:0]                        rsp_data_ff;
   logic                                 rsp_last_ff;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= rdss_pkg::TIME_STEP_RST;
         diff_gain_ff <= rdss_pkg::DIFF_GAIN_RST;
         inv_x_sq_ff  <= rdss_pkg::INV_X_SQ_RST;
         inv_y_sq_ff  <= rdss_pkg::INV_Y_SQ_RST;
         cols_cfg_ff  <= rdss_pkg::COLS_RST;
         rows_cfg_ff  <= rdss_pkg::ROWS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            rdss_pkg::CSR_TIME_STEP: time_step_ff <= csr_data;
            rdss_pkg::CSR_DIFF_GAIN: diff_gain_ff <= csr_data;
            rdss_pkg::CSR_INV_X_SQ:  inv_x_sq_ff  <= csr_data;
            rdss_pkg::CSR_INV_Y_SQ:  inv_y_sq_ff  <= csr_data;
            rdss_pkg::CSR_COLS:      cols_cfg_ff  <= csr_data[rdss_pkg::COLS_CFG_W-1:0];
            rdss_pkg::CSR_ROWS:      rows_cfg_ff  <= csr_data[rdss_pkg::ROWS_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A grid size of zero acts as one; column counts above the store depth and row counts above MAX_ROWS are clipped.
   always_comb begin
      if (cols_cfg_ff == '0) begin
         cols_eff = rdss_pkg::COLS_EFF_W'(1);
      end else if (int'(cols_cfg_ff) > rdss_pkg::MAX_COLS) begin
         cols_eff = rdss_pkg::COLS_EFF_W'(rdss_pkg::MAX_COLS);
      end else begin
         cols_eff = rdss_pkg::COLS_EFF_W'(cols_cfg_ff);
      end
      if (rows_cfg_ff == '0) begin
         rows_eff = rdss_pkg::ROW_W'(1);
      end else if (int'(rows_cfg_ff) > rdss_pkg::MAX_ROWS) begin
         rows_eff = rdss_pkg::ROW_W'(rdss_pkg::MAX_ROWS);
      end else begin
         rows_eff = rdss_pkg::ROW_W'(rows_cfg_ff);
      end
   end

   // Neighbourhood of the cell one row behind the incoming word.
   always_comb begin
      item_valid = (item_flush_ff == flushing_ff);
      col_plus   = rdss_pkg::COLS_EFF_W'(col_ff) + rdss_pkg::COLS_EFF_W'(1);
      row_end    = (col_plus >= cols_eff);
      row_plus   = row_ff + rdss_pkg::ROW_W'(1);
      down       = (item_flush_ff == rdss_pkg::CMD_FLUSH) ? '0 : cell_ff;
      up         = (row_ff >= rdss_pkg::ROW_W'(2)) ? up_rd_ff : '0;
      left       = (col_ff != '0) ? left_ff : '0;
      right      = row_end ? '0 : right_rd_ff;
      sx_in      = rdss_pkg::DIFF_W'(right) + rdss_pkg::DIFF_W'(left)
                   - (rdss_pkg::DIFF_W'(center_rd_ff) <<< 1);
      sy_in      = rdss_pkg::DIFF_W'(down) + rdss_pkg::DIFF_W'(up)
                   - (rdss_pkg::DIFF_W'(center_rd_ff) <<< 1);
      status.emit = item_valid && (row_ff != '0);

      col_in      = col_ff;
      row_in      = row_ff;
      flushing_in = flushing_ff;
      if (cmd.item_apply && item_valid) begin
         if (row_end) begin
            col_in = '0;
            if (item_flush_ff == rdss_pkg::CMD_FLUSH) begin
               row_in      = '0;
               flushing_in = 1'b0;
            end else begin
               row_in = row_plus;
               if (row_plus >= rows_eff) begin
                  flushing_in = 1'b1;
               end
            end
         end else begin
            col_in = col_plus[rdss_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         flushing_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         flushing_ff <= flushing_in;
      end
   end

   // Line stores: one write port, registered reads at the current and next column.
   always_comb begin
      store_we       = cmd.clear_wr || (cmd.item_apply && item_valid);
      store_addr     = cmd.clear_wr ? cmd.clear_addr : col_ff;
      above_wdata    = cmd.clear_wr ? '0 : down;
      two_back_wdata = cmd.clear_wr ? '0 : center_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         row_above_mem[store_addr]    <= above_wdata;
         row_two_back_mem[store_addr] <= two_back_wdata;
      end
      if (cmd.item_load) begin
         item_flush_ff <= req_tuser;
         cell_ff       <= req_tdata;
         center_rd_ff  <= row_above_mem[col_ff];
         right_rd_ff   <= row_above_mem[col_plus[rdss_pkg::COL_W-1:0]];
         up_rd_ff      <= row_two_back_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_apply && item_valid) begin
         left_ff   <= center_rd_ff;
         center_ff <= center_rd_ff;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         last_ff   <= (item_flush_ff == rdss_pkg::CMD_FLUSH) && row_end;
      end
   end

   // Shared multiplier and accumulator.
   always_comb begin
      unique case (cmd.a_sel)
         rdss_pkg::A_SX:     mul_a = rdss_pkg::MUL_A_W'(sx_ff);
         rdss_pkg::A_SY:     mul_a = rdss_pkg::MUL_A_W'(sy_ff);
         rdss_pkg::A_CENTER: mul_a = rdss_pkg::MUL_A_W'(center_ff);
         rdss_pkg::A_PROD:   mul_a = prod_ff[rdss_pkg::MUL_A_W-1:0];
         rdss_pkg::A_X_LO:   mul_a = {1'b0, x_ff[rdss_pkg::CHUNK_W-1:0]};
         rdss_pkg::A_X_HI:
            mul_a = rdss_pkg::MUL_A_W'($signed(x_ff[rdss_pkg::X_W-1:rdss_pkg::CHUNK_W]));
         default:            mul_a = '0;
      endcase
      unique case (cmd.b_sel)
         rdss_pkg::B_INV_X:  mul_b = {1'b0, inv_x_sq_ff};
         rdss_pkg::B_INV_Y:  mul_b = {1'b0, inv_y_sq_ff};
         rdss_pkg::B_GAIN:   mul_b = {1'b0, diff_gain_ff};
         rdss_pkg::B_CENTER: mul_b = rdss_pkg::MUL_B_W'(center_ff);
         rdss_pkg::B_STEP:   mul_b = {1'b0, time_step_ff};
         default:            mul_b = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      prod_ext = rdss_pkg::ACC_W'(prod_ff);
      unique case (cmd.shift_sel)
         rdss_pkg::SH_NONE:       prod_sh = prod_ext;
         rdss_pkg::SH_GAIN:       prod_sh = prod_ext <<< rdss_pkg::GAIN_SHIFT;
         rdss_pkg::SH_CHUNK:      prod_sh = prod_ext <<< rdss_pkg::CHUNK_W;
         rdss_pkg::SH_CHUNK_GAIN:
            prod_sh = prod_ext <<< (rdss_pkg::CHUNK_W + rdss_pkg::GAIN_SHIFT);
         default:                 prod_sh = prod_ext;
      endcase
      unique case (cmd.acc_op)
         rdss_pkg::ACC_HOLD:      acc_in = acc_ff;
         rdss_pkg::ACC_LOAD:      acc_in = prod_sh;
         rdss_pkg::ACC_ADD:       acc_in = acc_ff + prod_sh;
         rdss_pkg::ACC_SUB:       acc_in = acc_ff - prod_sh;
         rdss_pkg::ACC_CUBE_BASE:
            acc_in = rdss_pkg::ACC_W'(center_ff) <<< rdss_pkg::ONE_SHIFT;
         default:                 acc_in = acc_ff;
      endcase
      // Both roundings are half up, that is a floor after adding half an LSB.
      rate_full = (acc_ff + (rdss_pkg::ACC_W'(1) <<< (rdss_pkg::RATE_SHIFT - 1)))
                  >>> rdss_pkg::RATE_SHIFT;
      inc_full  = (acc_ff + (rdss_pkg::ACC_W'(1) <<< (rdss_pkg::INC_SHIFT - 1)))
                  >>> rdss_pkg::INC_SHIFT;
      unique case (cmd.x_op)
         rdss_pkg::X_HOLD:      x_in = x_ff;
         rdss_pkg::X_LOAD_ACC:  x_in = acc_ff[rdss_pkg::X_W-1:0];
         rdss_pkg::X_LOAD_RATE: x_in = rate_full[rdss_pkg::X_W-1:0];
         default:               x_in = x_ff;
      endcase
      sum = rdss_pkg::SUM_W'(center_ff) + $signed(inc_full[rdss_pkg::SUM_W-1:0]);
      if (sum > SAT_HI) begin
         sat_value = {1'b0, {(VW - 1){1'b1}}};
      end else if (sum < SAT_LO) begin
         sat_value = {1'b1, {(VW - 1){1'b0}}};
      end else begin
         sat_value = sum[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      if (cmd.out_load) begin
         rsp_data_ff <= sat_value;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

// ----- rtl/core/reaction_diffusion_stencil_step_core.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata: cell_value; tuser: command
// rsp_      out        rsp_tvalid/rsp_tready  tdata: new_value; tlast: last_of_frame
// csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// A word that yields a result steps the core through the whole stencil sequence, as the single shared
// multiplier and accumulator evaluate the stencil one partial product at a time.
// A word that yields no result (first row, or a word out of phase) passes through the read step back to idle.
// After reset the line stores are cleared one column per cycle; no word is taken meanwhile,
// but register writes are.
// A finished result waits in the output register while the next word is taken; the core
// holds in its last step only if a new result is ready before the previous one is taken.
`timescale 1ns / 1ps

`include "reaction_diffusion_stencil_step_core_assert.svh"

module reaction_diffusion_stencil_step_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rdss_pkg::VALUE_W-1:0]        req_tdata,   // [15:0] cell_value
   input  logic                                req_tuser,   // [0] command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rdss_pkg::VALUE_W-1:0]        rsp_tdata,   // [15:0] new_value
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rdss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rdss_pkg::CSR_DATA_W-1:0]     csr_data
);

   rdss_pkg::cmd_type    cmd;
   rdss_pkg::status_type status;

   assign csr_ready = 1'b1;

   rdss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rdss_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   `RDSS_ASSERT_NEXT_ALWAYS(a_no_word_during_clear, clock, reset, !req_tready, "word offered as taken during the store clear")
   `RDSS_ASSERT_NOW(a_result_only_into_free_slot, clock, reset, cmd.out_load, !rsp_tvalid || rsp_tready, "result overwrote a waiting word")
   `RDSS_ASSERT_NEXT(a_one_word_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "second word taken while one is in work")
   `RDSS_ASSERT_NOW(a_valid_rises_on_load, clock, reset, $rose(rsp_tvalid), $past(cmd.out_load), "result valid without a finished word")

endmodule
